// ===== rtl/bfa_pkg.sv =====
//----------------------------------------------------------------------------
// Bitmap first-free allocator package
// Shared types, codes and helper functions for the allocator modules.
//----------------------------------------------------------------------------
package bfa_pkg;

  localparam int BITMAP_BYTES_DEF = 4096;
  localparam int IDX_W            = 12;
  localparam int VAL_W            = 8;
  localparam int CNT_W            = 16;
  localparam int NUM_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE  = 2'd1;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_ALLOC = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             found;
    logic [NUM_W-1:0] number;
  } res_t;

  function automatic logic [2:0] first_zero(input logic [7:0] free_bits);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/bfa_engine.sv =====
//----------------------------------------------------------------------------
// Bitmap first-free allocator engine
// Holds the usage bitmap in a synchronous memory, clears it after reset,
// applies byte loads and scans one byte per cycle for the first free object.
//----------------------------------------------------------------------------
module bfa_engine #(
  parameter int BITMAP_BYTES = bfa_pkg::BITMAP_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bfa_pkg::kind_t              in_kind,
  input  logic [bfa_pkg::IDX_W-1:0]   in_byte_index,
  input  logic [bfa_pkg::VAL_W-1:0]   in_byte_value,
  input  logic [bfa_pkg::CNT_W-1:0]   object_count,
  input  logic                        number_base,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bfa_pkg::res_t               res
);
  import bfa_pkg::*;

  localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int LW = AW + 4;
  localparam logic [31:0] TOTAL = 32'(BITMAP_BYTES) * 32'd8;
  localparam logic [AW-1:0] LAST_ADDR = AW'(BITMAP_BYTES - 1);

  logic [VAL_W-1:0] mem [BITMAP_BYTES];

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] ev_r, ev_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [LW-1:0] lim_r, lim_nxt;
  res_t          res_r, res_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_data_r;

  logic [31:0]    idx_ext;
  logic [31:0]    cnt_ext;
  logic [31:0]    lim_sel;
  logic [LW-1:0]  lim_new;
  logic [LW-1:0]  lim_m1;
  logic [AW:0]    full_bytes;
  logic [AW:0]    ev_ext;
  logic [7:0]     vmask;
  logic [7:0]     free_bits;
  logic           hit;
  logic [2:0]     bit_pos;
  logic [AW+2:0]  obj_idx;
  logic [31:0]    obj_sum;

  assign idx_ext    = {{(32-IDX_W){1'b0}}, in_byte_index};
  assign cnt_ext    = {{(32-CNT_W){1'b0}}, object_count};
  assign lim_sel    = (cnt_ext > TOTAL) ? TOTAL : cnt_ext;
  assign lim_new    = lim_sel[LW-1:0];
  assign lim_m1     = lim_new - LW'(1);
  assign full_bytes = lim_r[LW-1:3];
  assign ev_ext     = {1'b0, ev_r};

  always_comb begin
    priority if (ev_ext < full_bytes) begin
      vmask = 8'hFF;
    end else if (ev_ext == full_bytes) begin
      vmask = (8'h01 << lim_r[2:0]) - 8'h01;
    end else begin
      vmask = 8'h00;
    end
  end

  assign free_bits = ~rd_data_r & vmask;
  assign hit       = |free_bits;
  assign bit_pos   = first_zero(free_bits);
  assign obj_idx   = {ev_r, bit_pos};
  assign obj_sum   = 32'(obj_idx) + 32'(number_base);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    ev_nxt    = ev_r;
    last_nxt  = last_r;
    lim_nxt   = lim_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ev_r;
    mem_wdata = rd_data_r | (8'h01 << bit_pos);
    rd_addr   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority if (in_kind == KIND_LOAD) begin
            mem_we    = (idx_ext < 32'(BITMAP_BYTES));
            mem_waddr = idx_ext[AW-1:0];
            mem_wdata = in_byte_value;
            res_nxt   = '0;
            state_nxt = ST_RESP;
          end else if (lim_new == '0) begin
            res_nxt   = '0;
            state_nxt = ST_RESP;
          end else begin
            lim_nxt   = lim_new;
            last_nxt  = lim_m1[AW+2:3];
            ev_nxt    = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_addr = (ev_r == last_r) ? ev_r : ev_r + AW'(1);
        priority if (hit) begin
          mem_we         = 1'b1;
          res_nxt.found  = 1'b1;
          res_nxt.number = obj_sum[NUM_W-1:0];
          state_nxt      = ST_RESP;
        end else if (ev_r == last_r) begin
          res_nxt   = '0;
          state_nxt = ST_RESP;
        end else begin
          ev_nxt = ev_r + AW'(1);
        end
      end
      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r   <= ev_nxt;
    last_r <= last_nxt;
    lim_r  <= lim_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

`ifndef NO_ASSERTIONS
  a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (mem_we && mem_wdata == '0 && !in_ready))
    else $error("clearing pass must write zero and hold off input");

  a_alloc_sets_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && mem_we) |-> ($countones(mem_wdata ^ rd_data_r) == 1))
    else $error("allocation must set exactly one new bit");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (ev_r <= last_r))
    else $error("scan went past the last byte");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_r)))
    else $error("pending result changed before it was taken");
`endif

endmodule

// ===== rtl/bitmap_first_free_allocator_top.sv =====
//----------------------------------------------------------------------------
// Bitmap first-free allocator top level
// Load transaction, or allocate with a zero object count: result registered in
// the engine, then in the output register, with no bitmap scan.
// Allocate transaction: bytes scanned in order (one memory read per byte) until
// a free object is found or the last byte is reached; next input only after the
// result leaves the engine. Reset: control registers cleared, then a clearing
// pass of all BITMAP_BYTES bytes, in_tready low; config writes taken out of reset.
//----------------------------------------------------------------------------
module bitmap_first_free_allocator_top #(
  parameter int BITMAP_BYTES = bfa_pkg::BITMAP_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,  // byte_index, byte_value, pad
  input  logic                             in_tuser,  // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata, // object_number
  output logic                             out_tuser, // found
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bfa_pkg::*;

  logic [CNT_W-1:0] object_count_r;
  logic             number_base_r;
  logic             out_valid_r;
  res_t             out_res_r;

  logic res_valid;
  logic res_ready;
  res_t res;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_tready;

  bfa_engine #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_kind       (kind_t'(in_tuser)),
    .in_byte_index (in_tdata[IDX_W-1:0]),
    .in_byte_value (in_tdata[IDX_W+VAL_W-1:IDX_W]),
    .object_count  (object_count_r),
    .number_base   (number_base_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_count_r <= '0;
      number_base_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_OBJECT_COUNT) begin
        object_count_r <= cfg_data[CNT_W-1:0];
      end
      if (cfg_index == REG_NUMBER_BASE) begin
        number_base_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.number;
  assign out_tuser  = out_res_r.found;

endmodule
